### sv/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy range allocator package
// Shared sizes, codes, item types and the controller-to-datapath interface.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int MAX_ORDER  = 8;
    localparam int TOP_BLOCKS = 16;
    localparam int NODES      = TOP_BLOCKS << MAX_ORDER;
    localparam int NODE_W     = $clog2(NODES);
    localparam int LINK_W     = NODE_W + 1;
    localparam int TOP_W      = NODE_W - MAX_ORDER;
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int HIDX_W     = $clog2(MAX_ORDER);
    localparam int ALL_UNITS  = TOP_BLOCKS << (MAX_ORDER - 1);

    localparam logic [LINK_W-1:0] NIL             = LINK_W'(NODES);
    localparam logic [31:0]       POOL_BASE_RESET = 32'h8000_0000;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        FL_FREE  = 2'd0,
        FL_USED  = 2'd1,
        FL_SPLIT = 2'd2
    } flag_t;

    typedef struct packed {
        logic        func;
        logic [7:0]  req_units;
        logic [31:0] free_start;
        logic [3:0]  free_order;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_start;
        logic [3:0]  block_order;
        logic [7:0]  block_units;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_RD_NODE,
        OP_RD_PAR,
        OP_RD_BUD,
        OP_A_UNL,
        OP_DEC,
        OP_A_SPL_LINK,
        OP_A_SPL_HALF,
        OP_A_USE,
        OP_F_FREE,
        OP_F_MERGE,
        OP_PUSH_LINK,
        OP_PUSH_HEAD,
        OP_FAIL,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic  clr_last;
        logic  is_free;
        logic  load_fail;
        logic  more;
        logic  at_top;
        flag_t rd_flag;
        logic  out_busy;
    } dp_status_t;

endpackage

### sv/bra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/bra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy range allocator datapath
// Tree flags, free list links and heads, working registers and result register.
// ----------------------------------------------------------------------------
module bra_dp
    import bra_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_op_t      op,
    output dp_status_t  sts,
    input  in_item_t    in_item,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [31:0]       pool_base_reg;
    logic [LINK_W-1:0] head_reg [MAX_ORDER];
    logic [NODE_W-1:0] node_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [ORD_W-1:0]  tgt_reg;
    logic [LINK_W-1:0] hd_reg;
    logic              func_reg;
    logic              fail_reg;
    logic [NODE_W-1:0] clr_cnt_reg;
    out_item_t         res_reg;
    out_item_t         m_data_reg;
    logic              m_valid_reg;

    logic              fl_we, nx_we, pv_we;
    logic [NODE_W-1:0] fl_waddr, nx_waddr, pv_waddr, rd_addr;
    logic [1:0]        fl_wdata, fl_rdata;
    logic [LINK_W-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    // Node geometry around the current node.
    logic [MAX_ORDER-1:0] cur_h;
    logic [TOP_W-1:0]     cur_top;
    logic [NODE_W-1:0]    lo_node, hi_node, par_node, bud_node;
    logic [HIDX_W-1:0]    head_idx;
    logic [LINK_W-1:0]    head_cur;

    assign cur_h    = node_reg[MAX_ORDER-1:0];
    assign cur_top  = node_reg[NODE_W-1:MAX_ORDER];
    assign lo_node  = {cur_top, cur_h[MAX_ORDER-2:0], 1'b0};
    assign hi_node  = {cur_top, cur_h[MAX_ORDER-2:0], 1'b1};
    assign par_node = {cur_top, 1'b0, cur_h[MAX_ORDER-1:1]};
    assign bud_node = node_reg ^ NODE_W'(1);
    assign head_idx = HIDX_W'(ord_reg - 1'b1);
    assign head_cur = head_reg[head_idx];

    // Allocate decode: order from unit count, then the smallest nonempty order.
    logic [3:0]        a_ord;
    logic              a_bad, k_found;
    logic [ORD_W-1:0]  k_sel;
    logic [NODE_W-1:0] k_node;

    always_comb begin
        a_ord = 4'd9;
        for (int i = 9; i >= 1; i--) begin
            if ((1 << (i - 1)) >= int'(in_item.req_units)) begin
                a_ord = 4'(i);
            end
        end
        a_bad   = (in_item.req_units == 8'd0) || (int'(a_ord) > MAX_ORDER);
        k_found = 1'b0;
        k_sel   = '0;
        k_node  = '0;
        for (int i = MAX_ORDER; i >= 1; i--) begin
            if (i >= int'(a_ord) && head_reg[i-1] != NIL) begin
                k_found = 1'b1;
                k_sel   = ORD_W'(i);
                k_node  = head_reg[i-1][NODE_W-1:0];
            end
        end
    end

    // Free decode: offset, checks and tree node of the block.
    logic [31:0]          f_off, f_mask;
    logic                 f_bad;
    logic [ORD_W-1:0]     f_ord;
    logic [MAX_ORDER-1:0] f_h;
    logic [NODE_W-1:0]    f_node;

    always_comb begin
        f_off  = in_item.free_start - pool_base_reg;
        f_ord  = ORD_W'(in_item.free_order);
        f_mask = (32'd1 << (in_item.free_order - 4'd1)) - 32'd1;
        f_bad  = (in_item.free_order == 4'd0) || (int'(in_item.free_order) > MAX_ORDER)
                 || (f_off >= 32'(ALL_UNITS)) || ((f_off & f_mask) != 32'd0);
        f_h    = (MAX_ORDER'(1) << (ORD_W'(MAX_ORDER) - f_ord))
                 + MAX_ORDER'(f_off[MAX_ORDER-2:0] >> (f_ord - 1'b1));
        f_node = {f_off[MAX_ORDER-1 +: TOP_W], f_h};
    end

    // Result of a successful allocate.
    logic [MAX_ORDER-1:0] u_rel;
    logic [31:0]          u_start;
    logic [7:0]           u_units;

    always_comb begin
        u_rel   = (cur_h - (MAX_ORDER'(1) << (ORD_W'(MAX_ORDER) - tgt_reg)))
                  << (tgt_reg - 1'b1);
        u_start = pool_base_reg + 32'({cur_top, u_rel[MAX_ORDER-2:0]});
        u_units = 8'(16'd1 << (tgt_reg - 1'b1));
    end

    // Reset contents of the link memories: top blocks chained ascending.
    logic [MAX_ORDER-1:0] c_h;
    logic [TOP_W-1:0]     c_top;
    logic [LINK_W-1:0]    c_next, c_prev;

    always_comb begin
        c_h    = clr_cnt_reg[MAX_ORDER-1:0];
        c_top  = clr_cnt_reg[NODE_W-1:MAX_ORDER];
        c_next = NIL;
        c_prev = NIL;
        if (c_h == MAX_ORDER'(1)) begin
            if (c_top != TOP_W'(TOP_BLOCKS - 1)) begin
                c_next = LINK_W'({c_top + 1'b1, MAX_ORDER'(1)});
            end
            if (c_top != '0) begin
                c_prev = LINK_W'({c_top - 1'b1, MAX_ORDER'(1)});
            end
        end
    end

    // Memory port control.
    always_comb begin
        fl_we    = 1'b0;
        fl_waddr = node_reg;
        fl_wdata = FL_FREE;
        nx_we    = 1'b0;
        nx_waddr = node_reg;
        nx_wdata = NIL;
        pv_we    = 1'b0;
        pv_waddr = node_reg;
        pv_wdata = NIL;
        rd_addr  = node_reg;
        case (op)
            OP_CLR: begin
                fl_we    = 1'b1;
                fl_waddr = clr_cnt_reg;
                nx_we    = 1'b1;
                nx_waddr = clr_cnt_reg;
                nx_wdata = c_next;
                pv_we    = 1'b1;
                pv_waddr = clr_cnt_reg;
                pv_wdata = c_prev;
            end
            OP_RD_PAR: rd_addr = par_node;
            OP_RD_BUD: rd_addr = bud_node;
            OP_A_UNL: begin
                pv_we    = (nx_rdata != NIL);
                pv_waddr = nx_rdata[NODE_W-1:0];
            end
            OP_A_SPL_LINK: begin
                fl_we    = 1'b1;
                fl_wdata = FL_SPLIT;
                nx_we    = 1'b1;
                nx_waddr = hi_node;
                nx_wdata = head_cur;
                pv_we    = 1'b1;
                pv_waddr = hi_node;
            end
            OP_A_SPL_HALF: begin
                fl_we    = 1'b1;
                fl_waddr = hi_node;
                pv_we    = (hd_reg != NIL);
                pv_waddr = hd_reg[NODE_W-1:0];
                pv_wdata = LINK_W'(hi_node);
            end
            OP_A_USE: begin
                fl_we    = 1'b1;
                fl_wdata = FL_USED;
            end
            OP_F_FREE: fl_we = 1'b1;
            OP_F_MERGE: begin
                fl_we    = 1'b1;
                fl_waddr = par_node;
                nx_we    = (pv_rdata != NIL);
                nx_waddr = pv_rdata[NODE_W-1:0];
                nx_wdata = nx_rdata;
                pv_we    = (nx_rdata != NIL);
                pv_waddr = nx_rdata[NODE_W-1:0];
                pv_wdata = pv_rdata;
            end
            OP_PUSH_LINK: begin
                nx_we    = 1'b1;
                nx_wdata = head_cur;
                pv_we    = 1'b1;
            end
            OP_PUSH_HEAD: begin
                pv_we    = (hd_reg != NIL);
                pv_waddr = hd_reg[NODE_W-1:0];
                pv_wdata = LINK_W'(node_reg);
            end
            default: ;
        endcase
    end

    bra_ram #(.WIDTH(2), .DEPTH(NODES)) u_flags (
        .aclk(aclk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(rd_addr), .rdata(fl_rdata)
    );

    bra_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_next (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(rd_addr), .rdata(nx_rdata)
    );

    bra_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prev (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(rd_addr), .rdata(pv_rdata)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= POOL_BASE_RESET;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++) begin
                head_reg[i] <= (i == MAX_ORDER - 1) ? LINK_W'(1) : NIL;
            end
        end else begin
            if (cfg_wr_en) begin
                pool_base_reg <= cfg_wr_data;
            end
            if (op == OP_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (op)
                OP_A_UNL:      head_reg[head_idx] <= nx_rdata;
                OP_A_SPL_HALF: head_reg[head_idx] <= hd_reg == NIL ? LINK_W'(hi_node)
                                                                   : LINK_W'(hi_node);
                OP_F_MERGE: begin
                    if (pv_rdata == NIL) begin
                        head_reg[head_idx] <= nx_rdata;
                    end
                end
                OP_PUSH_HEAD:  head_reg[head_idx] <= LINK_W'(node_reg);
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                func_reg <= in_item.func;
                if (in_item.func == FUNC_ALLOC) begin
                    tgt_reg  <= ORD_W'(a_ord);
                    ord_reg  <= k_sel;
                    node_reg <= k_node;
                    fail_reg <= a_bad || !k_found;
                    res_reg  <= '{status: (a_bad ? ST_BAD : ST_EMPTY), default: '0};
                end else begin
                    ord_reg  <= f_ord;
                    node_reg <= f_node;
                    fail_reg <= f_bad;
                    res_reg  <= '{status: ST_BAD, default: '0};
                end
            end
            OP_DEC:        ord_reg <= ord_reg - 1'b1;
            OP_A_SPL_LINK: hd_reg  <= head_cur;
            OP_A_SPL_HALF: node_reg <= lo_node;
            OP_A_USE: begin
                res_reg <= '{status: ST_OK, block_start: u_start,
                             block_order: 4'(tgt_reg), block_units: u_units};
            end
            OP_F_MERGE: begin
                node_reg <= par_node;
                ord_reg  <= ord_reg + 1'b1;
            end
            OP_PUSH_LINK:  hd_reg <= head_cur;
            OP_PUSH_HEAD:  res_reg <= '0;
            OP_FAIL:       res_reg <= '{status: ST_BAD, default: '0};
            OP_EMIT:       m_data_reg <= res_reg;
            default: ;
        endcase
    end

    assign sts.clr_last  = (clr_cnt_reg == NODE_W'(NODES - 1));
    assign sts.is_free   = (func_reg == FUNC_FREE);
    assign sts.load_fail = fail_reg;
    assign sts.more      = (ord_reg > tgt_reg);
    assign sts.at_top    = (cur_h == MAX_ORDER'(1));
    assign sts.rd_flag   = flag_t'(fl_rdata);
    assign sts.out_busy  = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### sv/bra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy range allocator controller
// Sequences the clearing pass, allocate splits and free merges.
// ----------------------------------------------------------------------------
module bra_ctrl
    import bra_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output dp_op_t     op
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP,
        S_A_RD, S_A_UNL, S_A_CHK, S_A_SL, S_A_SH,
        S_F_RD, S_F_CK1, S_F_CK2, S_F_SET, S_F_LOOP, S_F_CKB, S_F_PL, S_F_PH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLR: begin
                op = OP_CLR;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    op         = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (sts.load_fail) begin
                    state_next = S_DONE;
                end else if (sts.is_free) begin
                    state_next = S_F_RD;
                end else begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD: begin
                op         = OP_RD_NODE;
                state_next = S_A_UNL;
            end
            S_A_UNL: begin
                op         = OP_A_UNL;
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                if (sts.more) begin
                    op         = OP_DEC;
                    state_next = S_A_SL;
                end else begin
                    op         = OP_A_USE;
                    state_next = S_DONE;
                end
            end
            S_A_SL: begin
                op         = OP_A_SPL_LINK;
                state_next = S_A_SH;
            end
            S_A_SH: begin
                op         = OP_A_SPL_HALF;
                state_next = S_A_CHK;
            end
            S_F_RD: begin
                op         = OP_RD_NODE;
                state_next = S_F_CK1;
            end
            S_F_CK1: begin
                if (sts.rd_flag != FL_USED) begin
                    op         = OP_FAIL;
                    state_next = S_DONE;
                end else if (sts.at_top) begin
                    state_next = S_F_SET;
                end else begin
                    op         = OP_RD_PAR;
                    state_next = S_F_CK2;
                end
            end
            S_F_CK2: begin
                if (sts.rd_flag != FL_SPLIT) begin
                    op         = OP_FAIL;
                    state_next = S_DONE;
                end else begin
                    state_next = S_F_SET;
                end
            end
            S_F_SET: begin
                op         = OP_F_FREE;
                state_next = S_F_LOOP;
            end
            S_F_LOOP: begin
                if (sts.at_top) begin
                    state_next = S_F_PL;
                end else begin
                    op         = OP_RD_BUD;
                    state_next = S_F_CKB;
                end
            end
            S_F_CKB: begin
                if (sts.rd_flag == FL_FREE) begin
                    op         = OP_F_MERGE;
                    state_next = S_F_LOOP;
                end else begin
                    state_next = S_F_PL;
                end
            end
            S_F_PL: begin
                op         = OP_PUSH_LINK;
                state_next = S_F_PH;
            end
            S_F_PH: begin
                op         = OP_PUSH_HEAD;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
        s_ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

### sv/buddy_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy range allocator
// Hands out and takes back power-of-two blocks of IDs from a configured range.
// ----------------------------------------------------------------------------
// The block manages 16 top blocks of 128 IDs each, starting at pool_base.
// After reset it runs a clearing pass over all 4096 nodes of the node
// memories, during which s_ready stays low; pool_base may be written at any
// time the block is idle. Items are handled one at a time. An allocate item
// reads the head of the smallest nonempty list, unlinks it and then splits
// once per level down to the asked order; a free item that is accepted checks
// the block and, below the top, its parent, marks it free, merges with each
// free buddy on the way up and is then pushed onto its list, and a rejected
// item stops at the check that fails. The merge walk reads each buddy through
// the one shared read port of the node flag and link memories. The finished
// result sits in an output register, so a new item is accepted while the
// previous result still waits on m_ready.
module buddy_range_allocator
    import bra_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    dp_op_t     op;
    dp_status_t sts;

    // The controller walks the split and merge levels; the datapath owns the
    // memories, the free list heads and the result register.
    bra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .op      (op)
    );

    bra_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .sts         (sts),
        .in_item     (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

`ifndef SYNTHESIS
    // An accepted item keeps the input closed for at least the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // A failed item carries no block.
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.block_start == 32'd0 && m_data.block_order == 4'd0
            && m_data.block_units == 8'd0)
        else $error("failed item carries a block");

    // A block is only reported with a good status and a matching size.
    a_block_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.block_order != 4'd0 |->
            m_data.status == ST_OK && m_data.block_units != 8'd0)
        else $error("block reported with bad status or size");

    // Status codes above the no-free-block code never occur.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == ST_OK || m_data.status == ST_BAD
                    || m_data.status == ST_EMPTY)
        else $error("undefined status code");
`endif

endmodule

### sim/tb_buddy_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy range allocator testbench
// Drives allocate and free items through valid/ready with random gaps and
// stalls on both sides. A behavioral copy of the allocator's free lists and
// node flags predicts every result, and a short table of directed items with
// hand-written results opens the run. The pool base is changed between phases.
// ----------------------------------------------------------------------------
module tb_buddy_range_allocator;
    import bra_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int TOP_UNITS   = 1 << (MAX_ORDER - 1);

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    buddy_range_allocator dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Allocator state as the testbench believes it to be.
    // ------------------------------------------------------------------
    flag_t             tree_flag [NODES];
    logic [LINK_W-1:0] link_fwd  [NODES];
    logic [LINK_W-1:0] link_back [NODES];
    logic [LINK_W-1:0] order_head[MAX_ORDER];
    logic [31:0]       base_mirror;

    // Blocks currently held by the testbench, as offsets from the base.
    typedef struct {
        int unsigned offs;
        int unsigned ord;
    } held_t;
    held_t held_blocks[$];

    out_item_t expected_q[$];
    int        fail_count = 0;
    int        accepted_in = 0;
    int        checked_out = 0;
    int        alloc_ok = 0;
    int        free_ok = 0;
    int        bad_seen = 0;
    int        empty_seen = 0;

    // The directed table supplies a typed result alongside each of its items.
    logic      row_checked = 1'b0;
    out_item_t row_result = '0;

    function automatic void list_push(int unsigned n, int unsigned o);
        logic [LINK_W-1:0] hd;
        hd = order_head[o-1];
        link_fwd[n]  = hd;
        link_back[n] = NIL;
        if (hd != NIL) begin
            link_back[hd] = LINK_W'(n);
        end
        order_head[o-1] = LINK_W'(n);
    endfunction

    function automatic void list_unlink(int unsigned n, int unsigned o);
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
        nx = link_fwd[n];
        pv = link_back[n];
        if (pv == NIL) begin
            order_head[o-1] = nx;
        end else begin
            link_fwd[pv] = nx;
        end
        if (nx != NIL) begin
            link_back[nx] = pv;
        end
        link_fwd[n]  = NIL;
        link_back[n] = NIL;
    endfunction

    function automatic void allocator_reset();
        for (int i = 0; i < NODES; i++) begin
            tree_flag[i] = FL_FREE;
            link_fwd[i]  = NIL;
            link_back[i] = NIL;
        end
        for (int i = 0; i < MAX_ORDER; i++) begin
            order_head[i] = NIL;
        end
        for (int t = TOP_BLOCKS - 1; t >= 0; t--) begin
            list_push((t << MAX_ORDER) | 1, MAX_ORDER);
        end
        base_mirror = POOL_BASE_RESET;
    endfunction

    // Offset from the base of node n, which has order o.
    function automatic int unsigned node_to_offset(int unsigned n, int unsigned o);
        int unsigned h;
        h = n & ((1 << MAX_ORDER) - 1);
        return (n >> MAX_ORDER) * TOP_UNITS + ((h - (1 << (MAX_ORDER - o))) << (o - 1));
    endfunction

    function automatic out_item_t run_allocate(int unsigned units);
        out_item_t   r;
        int unsigned o;
        int unsigned k;
        int unsigned n;
        int unsigned lo;
        r = '0;
        o = 1;
        if (units == 0) begin
            r.status = ST_BAD;
            return r;
        end
        while (o <= 9 && (1 << (o - 1)) < units) o++;
        if (o > MAX_ORDER) begin
            r.status = ST_BAD;
            return r;
        end
        k = o;
        while (k <= MAX_ORDER && order_head[k-1] == NIL) k++;
        if (k > MAX_ORDER) begin
            r.status = ST_EMPTY;
            return r;
        end
        n = order_head[k-1];
        list_unlink(n, k);
        // Split down to the asked order, keeping the lower half each time.
        while (k > o) begin
            lo = (n & ~((1 << MAX_ORDER) - 1)) | ((n & ((1 << MAX_ORDER) - 1)) << 1);
            tree_flag[n]      = FL_SPLIT;
            tree_flag[lo]     = FL_FREE;
            tree_flag[lo | 1] = FL_FREE;
            k--;
            list_push(lo | 1, k);
            n = lo;
        end
        tree_flag[n]  = FL_USED;
        r.status      = ST_OK;
        r.block_start = base_mirror + 32'(node_to_offset(n, o));
        r.block_order = 4'(o);
        r.block_units = 8'(1 << (o - 1));
        return r;
    endfunction

    function automatic out_item_t run_free(logic [31:0] start, int unsigned o);
        out_item_t   r;
        logic [31:0] offs;
        int unsigned h;
        int unsigned n;
        int unsigned hh;
        r = '0;
        offs = start - base_mirror;
        if (o < 1 || o > MAX_ORDER || offs >= ALL_UNITS
                || (offs & ((1 << (o - 1)) - 1)) != 0) begin
            r.status = ST_BAD;
            return r;
        end
        h = (1 << (MAX_ORDER - o)) + ((offs % TOP_UNITS) >> (o - 1));
        n = ((offs / TOP_UNITS) << MAX_ORDER) | h;
        // Only an allocated block whose parent is split may be freed.
        if (tree_flag[n] != FL_USED || (h != 1
                && tree_flag[(n & ~((1 << MAX_ORDER) - 1)) | (h >> 1)] != FL_SPLIT)) begin
            r.status = ST_BAD;
            return r;
        end
        tree_flag[n] = FL_FREE;
        forever begin
            hh = n & ((1 << MAX_ORDER) - 1);
            if (hh == 1 || tree_flag[n ^ 1] != FL_FREE) break;
            list_unlink(n ^ 1, o);
            n = (n & ~((1 << MAX_ORDER) - 1)) | (hh >> 1);
            tree_flag[n] = FL_FREE;
            o++;
        end
        list_push(n, o);
        r.status = ST_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: every accepted item is predicted at its accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t   p;
        int unsigned offs;
        if (aresetn && s_valid && s_ready) begin
            accepted_in++;
            if (s_data.func == FUNC_ALLOC) begin
                p = run_allocate(s_data.req_units);
            end else begin
                p = run_free(s_data.free_start, s_data.free_order);
            end
            if (p.status == ST_OK && s_data.func == FUNC_ALLOC) begin
                held_blocks.push_back('{p.block_start - base_mirror, p.block_order});
                alloc_ok++;
            end else if (p.status == ST_OK) begin
                offs = s_data.free_start - base_mirror;
                foreach (held_blocks[i]) begin
                    if (held_blocks[i].offs == offs && held_blocks[i].ord == s_data.free_order) begin
                        held_blocks.delete(i);
                        break;
                    end
                end
                free_ok++;
            end else if (p.status == ST_BAD) begin
                bad_seen++;
            end else begin
                empty_seen++;
            end
            expected_q.push_back(row_checked ? row_result : p);
        end
    end

    // ------------------------------------------------------------------
    // Output side: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            checked_out++;
            if (expected_q.size() == 0) begin
                $error("result with no expectation waiting: %p", m_data);
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                if (m_data.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_data.status);
                    fail_count++;
                end
                if (m_data.block_start !== e.block_start) begin
                    $error("block_start: expected %h, actual %h", e.block_start,
                           m_data.block_start);
                    fail_count++;
                end
                if (m_data.block_order !== e.block_order) begin
                    $error("block_order: expected %0d, actual %0d", e.block_order,
                           m_data.block_order);
                    fail_count++;
                end
                if (m_data.block_units !== e.block_units) begin
                    $error("block_units: expected %0d, actual %0d", e.block_units,
                           m_data.block_units);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: mostly ready, short random stalls, a few long ones. Raising
    // hold_token asks for one very long hold-off so the block backs up and
    // drops s_ready while the sender keeps offering items.
    // ------------------------------------------------------------------
    int hold_token = 0;
    int hold_seen = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        int pick;
        if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                stall_left = $urandom_range(10, 60);
                m_ready <= 1'b0;
            end else if (pick < 20) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender.
    // ------------------------------------------------------------------
    task automatic send_item(in_item_t it, logic chk, out_item_t res);
        int gap;
        s_valid     <= 1'b1;
        s_data      <= it;
        row_checked <= chk;
        row_result  <= res;
        do @(posedge aclk); while (!s_ready);
        gap = $urandom_range(0, 99);
        if (gap < 60) begin
            gap = 0;
        end else if (gap < 95) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(10, 50);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        // Let the block sit idle a while before anything else is driven.
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_base(logic [31:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        base_mirror = value;
    endtask

    function automatic in_item_t make_item(logic func, int unsigned units,
                                           logic [31:0] start, int unsigned ord);
        in_item_t it;
        it.func       = func;
        it.req_units  = 8'(units);
        it.free_start = start;
        it.free_order = 4'(ord);
        return it;
    endfunction

    // Mostly well-formed traffic: allocations of mixed sizes and frees of
    // held blocks, with some broken frees and fully random noise.
    function automatic in_item_t random_item(int alloc_pct);
        int          pick;
        int          idx;
        int unsigned units;
        held_t       hb;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            return make_item($urandom_range(0, 1), $urandom_range(0, 255), $urandom,
                             $urandom_range(0, 15));
        end
        if ($urandom_range(0, 99) < alloc_pct || held_blocks.size() == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                units = $urandom_range(1, 16);
            end else if (pick < 90) begin
                units = $urandom_range(17, 128);
            end else begin
                units = $urandom_range(0, 255);
            end
            return make_item(FUNC_ALLOC, units, $urandom, $urandom_range(0, 15));
        end
        idx = $urandom_range(0, held_blocks.size() - 1);
        hb  = held_blocks[idx];
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            // Random order for a held block, often the wrong one.
            return make_item(FUNC_FREE, $urandom, base_mirror + hb.offs,
                             $urandom_range(1, MAX_ORDER));
        end else if (pick < 7) begin
            // Parent of a held block, which is split.
            return make_item(FUNC_FREE, $urandom,
                             base_mirror + (hb.offs & ~((1 << hb.ord) - 1)),
                             (hb.ord < MAX_ORDER) ? hb.ord + 1 : hb.ord);
        end
        return make_item(FUNC_FREE, $urandom, base_mirror + hb.offs, hb.ord);
    endfunction

    typedef struct {
        in_item_t  it;
        logic      chk;
        out_item_t res;
    } dir_row_t;

    localparam out_item_t R_BAD   = '{ST_BAD, 32'd0, 4'd0, 8'd0};
    localparam out_item_t R_FREED = '{ST_OK, 32'd0, 4'd0, 8'd0};

    dir_row_t    dir_rows[$];
    logic [31:0] phase_base[4] = '{32'h0000_0000, 32'hFFFF_FF80, 32'h1234_5600, 32'hFFFF_FFFF};
    int          phase_alloc[4] = '{55, 80, 45, 65};

    initial begin
        allocator_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items. With reset base 2^31 a single unit comes from the
        // bottom of block zero, and the whole-block request takes block one.
        dir_rows = '{
            '{make_item(FUNC_ALLOC, 0, 0, 0), 1'b1, R_BAD},
            '{make_item(FUNC_ALLOC, 129, 0, 0), 1'b1, R_BAD},
            '{make_item(FUNC_ALLOC, 255, 0, 0), 1'b1, R_BAD},
            '{make_item(FUNC_ALLOC, 1, 0, 0), 1'b1, '{ST_OK, 32'h8000_0000, 4'd1, 8'd1}},
            '{make_item(FUNC_ALLOC, 128, 0, 0), 1'b1, '{ST_OK, 32'h8000_0080, 4'd8, 8'd128}},
            '{make_item(FUNC_FREE, 0, 32'h8000_0000, 1), 1'b1, R_FREED},
            // Double free.
            '{make_item(FUNC_FREE, 0, 32'h8000_0000, 1), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0080, 0), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0080, 9), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0080, 15), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h7FFF_FFFF, 1), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0800, 1), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0001, 2), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 255, 32'hFFFF_FFFF, 8), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0080, 8), 1'b1, R_FREED},
            '{make_item(FUNC_ALLOC, 2, 0, 0), 1'b0, R_FREED},
            '{make_item(FUNC_ALLOC, 3, 0, 0), 1'b0, R_FREED},
            '{make_item(FUNC_ALLOC, 5, 32'hFFFF_FFFF, 15), 1'b0, R_FREED},
            '{make_item(FUNC_ALLOC, 64, 0, 0), 1'b0, R_FREED},
            '{make_item(FUNC_ALLOC, 127, 0, 0), 1'b0, R_FREED},
            // Block one is now split, so freeing it whole is refused.
            '{make_item(FUNC_FREE, 0, 32'h8000_0080, 8), 1'b1, R_BAD},
            '{make_item(FUNC_FREE, 0, 32'h8000_0002, 2), 1'b0, R_FREED},
            '{make_item(FUNC_FREE, 0, 32'h8000_0004, 3), 1'b0, R_FREED}
        };
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].res);
        end

        // Random phases, each under its own pool base.
        for (int ph = 0; ph < 4; ph++) begin
            write_base(phase_base[ph]);
            for (int i = 0; i < 500; i++) begin
                if (ph == 0 && i == 100) begin
                    hold_token++;
                end
                if (ph == 1 && i == 250) begin
                    // Sender pauses until every result is back.
                    drain_results();
                end
                send_item(random_item(phase_alloc[ph]), 1'b0, R_FREED);
            end
        end
        write_base(POOL_BASE_RESET);

        drain_results();
        $display("Run covered %0d items: %0d allocations and %0d frees succeeded,",
                 accepted_in, alloc_ok, free_ok);
        $display("%0d rejected, %0d hit an empty pool, %0d results checked.",
                 bad_seen, empty_seen, checked_out);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
